>>> sv/nfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared types for the next-fit segment allocator: state codes, result
// codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package nfsa_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_ALLOC,
    S_REL_L,
    S_REL_R,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ID    = 2'd1,
    ST_NOFIT = 2'd2,
    ST_FULL  = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_SRCH,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef struct packed {
    logic    accept_req;
    logic    cfg_wr;
    logic    scan_step;
    logic    find_hit;
    logic    srch_init;
    logic    srch_step;
    logic    take_exact;
    logic    split;
    logic    rel_left;
    logic    rel_right;
    logic    set_st;
    res_t    st_code;
    logic    out_load;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic size_zero;
    logic scan_end;
    logic owner_match;
    logic fit_ok;
    logic fit_exact;
    logic table_full;
    logic left_merge;
    logic right_merge;
    logic out_free;
  } stat_t;

endpackage

>>> sv/nfsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_ctrl
// Sequencer: owner lookup, next-fit search, split/take and release merges.
// ----------------------------------------------------------------------------
module nfsa_ctrl
  import nfsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st_code = ST_OK;
    cmd.rd_sel  = RD_SCAN;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // a pending table write goes first, the request waits until it is taken
        in_ready  = !cfg_valid;
        cfg_ready = 1'b1;
        cmd.cfg_wr = cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.accept_req = 1'b1;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        cmd.rd_sel = RD_SCAN;
        if (stat.scan_end) begin
          if (stat.op == OP_RELEASE) begin
            cmd.set_st = 1'b1;
            cmd.st_code = ST_ID;
            state_nxt = S_DONE;
          end else if (stat.size_zero) begin
            cmd.set_st = 1'b1;
            cmd.st_code = ST_NOFIT;
            state_nxt = S_DONE;
          end else begin
            cmd.srch_init = 1'b1;
            state_nxt = S_ALLOC;
          end
        end else if (stat.owner_match) begin
          if (stat.op == OP_RELEASE) begin
            cmd.find_hit = 1'b1;
            state_nxt = S_REL_L;
          end else begin
            cmd.set_st = 1'b1;
            cmd.st_code = ST_ID;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_ALLOC: begin
        cmd.rd_sel = RD_SRCH;
        if (stat.scan_end) begin
          cmd.set_st = 1'b1;
          cmd.st_code = ST_NOFIT;
          state_nxt = S_DONE;
        end else if (stat.fit_ok) begin
          cmd.set_st = 1'b1;
          state_nxt = S_DONE;
          if (stat.fit_exact) begin
            cmd.take_exact = 1'b1;
          end else if (stat.table_full) begin
            cmd.st_code = ST_FULL;
          end else begin
            cmd.split = 1'b1;
          end
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_REL_L: begin
        cmd.rd_sel = RD_LEFT;
        cmd.rel_left = 1'b1;
        state_nxt = S_REL_R;
      end
      S_REL_R: begin
        cmd.rd_sel = RD_RIGHT;
        cmd.rel_right = 1'b1;
        cmd.set_st = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/nfsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_dp
// Segment table, search counters, cursor and result register.
// ----------------------------------------------------------------------------
module nfsa_dp
  import nfsa_pkg::*;
#(
  parameter int MEM_UNITS    = 1024,
  parameter int MAX_SEGMENTS = 32,
  parameter int ID_BITS      = 8,
  parameter int SIZE_W       = $clog2(MEM_UNITS + 1),
  parameter int ADDR_W       = $clog2(MEM_UNITS)
)(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               in_operation,
  input  logic [ID_BITS-1:0] in_process_id,
  input  logic [SIZE_W-1:0]  in_request_size,
  input  logic [SIZE_W-1:0]  cfg_total_units,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [ADDR_W-1:0]  out_block_start
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);
  localparam logic [SIZE_W-1:0] MEM_SZ = SIZE_W'(MEM_UNITS);

  logic [ADDR_W-1:0]  seg_start_r [MAX_SEGMENTS];
  logic [SIZE_W-1:0]  seg_size_r  [MAX_SEGMENTS];
  logic [ID_BITS-1:0] seg_owner_r [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] seg_used_r;

  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   cursor_r;
  logic [CNT_W-1:0]   k_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   fidx_r;
  logic [SIZE_W-1:0]  fsize_r;
  op_t                op_r;
  logic [ID_BITS-1:0] id_r;
  logic [SIZE_W-1:0]  req_r;
  res_t               st_r;
  logic [ADDR_W-1:0]  blk_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [ADDR_W-1:0]  out_start_r;

  logic [IDX_W-1:0]   rd_idx;
  logic [ADDR_W-1:0]  rd_start;
  logic [SIZE_W-1:0]  rd_size;
  logic [ID_BITS-1:0] rd_owner;
  logic               rd_used;
  logic [SIZE_W-1:0]  cfg_clamp;
  logic [IDX_W-1:0]   fidx_p1;
  logic [IDX_W-1:0]   idx_p1;
  logic               left_ok;
  logic               right_ok;
  logic               do_rm;
  logic [IDX_W-1:0]   rm_idx;
  logic [SIZE_W-1:0]  msum;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SCAN:  rd_idx = k_r[IDX_W-1:0];
      RD_SRCH:  rd_idx = idx_r;
      RD_LEFT:  rd_idx = fidx_r - IDX_W'(1);
      RD_RIGHT: rd_idx = fidx_p1;
      default:  rd_idx = k_r[IDX_W-1:0];
    endcase
  end

  assign rd_start = seg_start_r[rd_idx];
  assign rd_size  = seg_size_r[rd_idx];
  assign rd_owner = seg_owner_r[rd_idx];
  assign rd_used  = seg_used_r[rd_idx];
  assign fidx_p1  = fidx_r + IDX_W'(1);
  assign idx_p1   = idx_r + IDX_W'(1);

  assign left_ok  = (fidx_r != '0) && !rd_used;
  assign right_ok = ({1'b0, fidx_r} + (IDX_W + 1)'(1) < (IDX_W + 1)'(count_r)) && !rd_used;

  // a merge folds entry rm_idx into rm_idx-1 and shifts the rest down
  assign do_rm  = (cmd.rel_left && left_ok) || (cmd.rel_right && right_ok);
  assign rm_idx = cmd.rel_left ? fidx_r : fidx_p1;
  assign msum   = rd_size + fsize_r;

  always_comb begin
    cfg_clamp = cfg_total_units;
    if (cfg_total_units == '0) begin
      cfg_clamp = SIZE_W'(1);
    end else if (cfg_total_units > MEM_SZ) begin
      cfg_clamp = MEM_SZ;
    end
  end

  always_comb begin
    stat.op          = op_r;
    stat.size_zero   = (req_r == '0);
    stat.scan_end    = (k_r == count_r);
    stat.owner_match = rd_used && (rd_owner == id_r);
    stat.fit_ok      = !rd_used && (rd_size >= req_r);
    stat.fit_exact   = (rd_size == req_r);
    stat.table_full  = (count_r >= MAX_CNT);
    stat.left_merge  = left_ok;
    stat.right_merge = right_ok;
    stat.out_free    = !out_valid_r || out_ready;
  end

  // segment table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_used_r     <= '0;
      seg_start_r[0] <= '0;
      seg_size_r[0]  <= MEM_SZ;
    end else if (cmd.cfg_wr) begin
      seg_used_r     <= '0;
      seg_start_r[0] <= '0;
      seg_size_r[0]  <= cfg_clamp;
    end else if (cmd.take_exact) begin
      seg_used_r[idx_r]  <= 1'b1;
      seg_owner_r[idx_r] <= id_r;
    end else if (cmd.split) begin
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        if (IDX_W'(i) == idx_r) begin
          seg_size_r[i]  <= req_r;
          seg_used_r[i]  <= 1'b1;
          seg_owner_r[i] <= id_r;
        end else if (i > 0 && IDX_W'(i) == idx_p1) begin
          seg_start_r[i] <= rd_start + req_r[ADDR_W-1:0];
          seg_size_r[i]  <= rd_size - req_r;
          seg_used_r[i]  <= 1'b0;
        end else if (i > 0 && IDX_W'(i) > idx_p1 && CNT_W'(i) <= count_r) begin
          seg_start_r[i] <= seg_start_r[i-1];
          seg_size_r[i]  <= seg_size_r[i-1];
          seg_used_r[i]  <= seg_used_r[i-1];
          seg_owner_r[i] <= seg_owner_r[i-1];
        end
      end
    end else if (cmd.rel_left || cmd.rel_right) begin
      if (cmd.rel_left) begin
        seg_used_r[fidx_r] <= 1'b0;
      end
      if (do_rm) begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
          if (i + 1 < MAX_SEGMENTS && IDX_W'(i) == rm_idx - IDX_W'(1)) begin
            seg_size_r[i] <= msum;
          end else if (i + 1 < MAX_SEGMENTS && IDX_W'(i) >= rm_idx && rm_idx != '0) begin
            seg_start_r[i] <= seg_start_r[i+1];
            seg_size_r[i]  <= seg_size_r[i+1];
            seg_used_r[i]  <= seg_used_r[i+1];
            seg_owner_r[i] <= seg_owner_r[i+1];
          end
        end
      end
    end
  end

  // count and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= CNT_W'(1);
      cursor_r <= '0;
    end else if (cmd.cfg_wr) begin
      count_r  <= CNT_W'(1);
      cursor_r <= '0;
    end else if (cmd.take_exact) begin
      cursor_r <= idx_r;
    end else if (cmd.split) begin
      count_r  <= count_r + CNT_W'(1);
      cursor_r <= idx_p1;
    end else if (do_rm) begin
      count_r <= count_r - CNT_W'(1);
      if (cursor_r >= rm_idx) begin
        cursor_r <= cursor_r - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_req) begin
      op_r  <= op_t'(in_operation);
      id_r  <= in_process_id;
      req_r <= in_request_size;
      k_r   <= '0;
    end else if (cmd.scan_step) begin
      k_r <= k_r + CNT_W'(1);
    end else if (cmd.srch_init) begin
      k_r   <= '0;
      idx_r <= cursor_r;
    end else if (cmd.srch_step) begin
      k_r   <= k_r + CNT_W'(1);
      idx_r <= (CNT_W'(idx_p1) == count_r || idx_p1 == '0) ? '0 : idx_p1;
    end
    if (cmd.find_hit) begin
      fidx_r  <= k_r[IDX_W-1:0];
      fsize_r <= rd_size;
    end else if (cmd.rel_left && left_ok) begin
      fidx_r  <= fidx_r - IDX_W'(1);
      fsize_r <= msum;
    end
    if (cmd.set_st) begin
      st_r  <= cmd.st_code;
      blk_r <= (cmd.take_exact || cmd.split) ? rd_start : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_start_r  <= blk_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_start = out_start_r;

endmodule

>>> sv/next_fit_segment_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_segment_allocator
// Next-fit allocator over an ordered segment table with split and merge.
// ----------------------------------------------------------------------------
// One request at a time. A request first walks the table one entry per
// cycle to look up the id; an allocate then walks again from the search
// cursor, one entry per cycle, and splits or takes the first fit (or reports
// the table full when a split is needed); a release does the left merge and
// then the right merge. The sequencer steps through the table over a single
// read port; the result is handed off in S_DONE and the next request is taken
// in S_IDLE. A new request is taken while the previous result still waits in
// the output register. Writing total_units resets the table and takes
// precedence over a request offered in the same cycle.
module next_fit_segment_allocator
  import nfsa_pkg::*;
#(
  parameter int MEM_UNITS    = 1024,
  parameter int MAX_SEGMENTS = 32,
  parameter int ID_BITS      = 8
)(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [ID_BITS-1:0]                in_process_id,
  input  logic [$clog2(MEM_UNITS + 1)-1:0]  in_request_size,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [$clog2(MEM_UNITS + 1)-1:0]  cfg_total_units,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [$clog2(MEM_UNITS)-1:0]      out_block_start
);

  cmd_t  cmd;
  stat_t stat;

  nfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfsa_dp #(
    .MEM_UNITS    (MEM_UNITS),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_operation),
    .in_process_id   (in_process_id),
    .in_request_size (in_request_size),
    .cfg_total_units (cfg_total_units),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_block_start (out_block_start)
  );

endmodule
